>>> hdl/lyndon_pkg.sv
// shared types and constants for the lyndon factorization unit
// no dependencies

package lyndon_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int CHAR_W          = 8;
    localparam int FACTOR_START_W  = 6;
    localparam int FACTOR_LENGTH_W = 7;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              end_of_string;
    } char_word_t;

    typedef struct packed {
        logic [FACTOR_START_W-1:0]  factor_start;
        logic [FACTOR_LENGTH_W-1:0] factor_length;
        logic                       last_factor;
        logic                       truncated;
    } factor_word_t;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_OUTER = 5'b00010,
        S_CHECK = 5'b00100,
        S_CMP   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

endpackage

>>> hdl/lyndon_store.sv
// character store: one write port, two registered read ports
// depends on lyndon_pkg

module lyndon_store
    import lyndon_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_a_addr,
    input  logic [AW-1:0]     rd_b_addr,
    output logic [CHAR_W-1:0] rd_a_data,
    output logic [CHAR_W-1:0] rd_b_data
);

    logic [CHAR_W-1:0] mem [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_data <= mem[rd_a_addr];
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

>>> hdl/lyndon_factorization_unit.sv
// top level: Duval sequencer around the character store
// depends on lyndon_pkg and lyndon_store
//
//   channel   direction  handshake             word
//   char      in         char_valid/stall      char_word_t
//   factor    out        factor_valid/stall    factor_word_t
//
// one byte is taken per cycle while loading; a final byte starts the scan and the block
// takes no byte until the scan ends: after the last factor enters the output register, S_OUTER
// finds no byte left and returns to S_LOAD; each comparison is a read issue (S_CHECK) and a
// compare (S_CMP) through the store read ports, and each factor is emitted from S_EMIT, which
// waits out any output stall
// reset clears the count and control; store contents need no clearing

module lyndon_factorization_unit
    import lyndon_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_word_t   char_word,
    output logic         factor_valid,
    input  logic         factor_stall,
    output factor_word_t factor_word
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = CW + 1;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [CW-1:0]  n_reg, n_next;
    logic           trunc_reg, trunc_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  len_reg, len_next;
    logic           out_valid_reg, out_valid_next;
    factor_word_t   out_word_reg, out_word_next;

    logic              char_accept;
    logic              store_full;
    logic              wr_en;
    logic              rd_en;
    logic [CHAR_W-1:0] rd_a_data;
    logic [CHAR_W-1:0] rd_b_data;
    logic              out_free;
    logic              out_load;
    logic [SW-1:0]     i_plus_len;

    assign char_stall   = (state_reg != S_LOAD);
    assign char_accept  = char_valid && !char_stall;
    assign store_full   = (count_reg == CW'(MAX_LEN));
    assign wr_en        = char_accept && !store_full;
    assign rd_en        = (state_reg == S_CHECK);
    assign out_free     = !out_valid_reg || !factor_stall;
    assign out_load     = (state_reg == S_EMIT) && out_free;
    assign i_plus_len   = SW'(i_reg) + SW'(len_reg);
    assign factor_valid = out_valid_reg;
    assign factor_word  = out_word_reg;

    lyndon_store #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[AW-1:0]),
        .wr_data   (char_word.char_byte),
        .rd_en     (rd_en),
        .rd_a_addr (k_reg[AW-1:0]),
        .rd_b_addr (j_reg[AW-1:0]),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        trunc_next     = trunc_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!factor_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (char_accept)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (char_word.end_of_string)
                    begin
                        n_next     = store_full ? count_reg : count_reg + 1'b1;
                        trunc_next = store_full | ovf_reg;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        i_next     = '0;
                        state_next = S_OUTER;
                    end
                end
            end
            S_OUTER:
            begin
                if (i_reg < n_reg)
                begin
                    j_next     = i_reg + 1'b1;
                    k_next     = i_reg;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_CHECK:
            begin
                if (j_reg < n_reg)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    len_next   = j_reg - k_reg;
                    state_next = S_EMIT;
                end
            end
            S_CMP:
            begin
                if (rd_a_data <= rd_b_data)
                begin
                    k_next     = (rd_a_data < rd_b_data) ? i_reg : k_reg + 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    len_next   = j_reg - k_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_word_next.factor_start  = FACTOR_START_W'(i_reg);
                    out_word_next.factor_length = FACTOR_LENGTH_W'(len_reg);
                    out_word_next.last_factor   = (i_plus_len >= SW'(n_reg));
                    out_word_next.truncated     = trunc_reg;
                    i_next                      = CW'(i_plus_len);
                    if (i_plus_len > SW'(k_reg))
                    begin
                        state_next = S_OUTER;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        trunc_reg    <= trunc_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        len_reg      <= len_next;
        out_word_reg <= out_word_next;
    end

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_CHECK)
        else $error("compare without a read issued the cycle before");

    a_k_before_j: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK || state_reg == S_CMP) |-> k_reg < j_reg)
        else $error("scan index order broken");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> (len_reg != '0 && len_reg <= n_reg))
        else $error("bad factor length");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LEN))
        else $error("character count past capacity");

    a_no_load_while_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_LOAD)
        else $error("store written during scan");

endmodule

>>> verif/lyndon_checker.sv
`timescale 1ns / 1ps
// checker for the lyndon factorization unit: rebuilds each string from the char words,
// splits it into lyndon factors and compares them with the factor words
// depends on lyndon_pkg

module lyndon_checker
    import lyndon_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    input  logic         char_stall,
    input  char_word_t   char_word,
    input  logic         factor_valid,
    input  logic         factor_stall,
    input  factor_word_t factor_word,
    output int           mismatches,
    output int           factors_due
);

    logic [CHAR_W-1:0] char_store [MAX_LEN_DEF];
    int                stored_len;
    logic              dropped;
    factor_word_t      due_factors [$];

    function automatic string fmt_factor(input factor_word_t f);
        return $sformatf("start %0d length %0d last %0b truncated %0b",
                         f.factor_start, f.factor_length, f.last_factor, f.truncated);
    endfunction

    // duval scan over the stored prefix
    task automatic split_into_factors();
        int           n;
        int           i;
        int           j;
        int           k;
        int           flen;
        factor_word_t f;
        n = stored_len;
        i = 0;
        while (i < n)
        begin
            j = i + 1;
            k = i;
            while (j < n && char_store[k] <= char_store[j])
            begin
                if (char_store[k] < char_store[j])
                    k = i;
                else
                    k++;
                j++;
            end
            flen = j - k;
            while (i <= k)
            begin
                f.factor_start  = FACTOR_START_W'(i);
                f.factor_length = FACTOR_LENGTH_W'(flen);
                f.last_factor   = (i + flen >= n);
                f.truncated     = dropped;
                due_factors     = {due_factors, f};
                i += flen;
            end
        end
    endtask

    task automatic take_char(input char_word_t w);
        if (stored_len < MAX_LEN_DEF)
        begin
            char_store[stored_len] = w.char_byte;
            stored_len++;
        end
        else
            dropped = 1'b1;
        if (w.end_of_string)
        begin
            split_into_factors();
            stored_len = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic check_factor(input factor_word_t got);
        factor_word_t want;
        if (due_factors.size() == 0)
        begin
            $display("%0t: factor word with none expected, got %s", $time, fmt_factor(got));
            mismatches++;
        end
        else
        begin
            want = due_factors.pop_front();
            if (got.factor_start !== want.factor_start
                || got.factor_length !== want.factor_length
                || got.last_factor !== want.last_factor
                || got.truncated !== want.truncated)
            begin
                $display("%0t: factor mismatch, expected %s, got %s",
                         $time, fmt_factor(want), fmt_factor(got));
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_len  = 0;
            dropped     = 1'b0;
            mismatches  = 0;
            due_factors.delete();
            factors_due = 0;
        end
        else
        begin
            if (char_valid && !char_stall)
                take_char(char_word);
            if (factor_valid && !factor_stall)
                check_factor(factor_word);
            factors_due = due_factors.size();
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the lyndon factorization unit: drives strings of char words,
// stalls the factor channel and reports the verdict; depends on lyndon_pkg,
// lyndon_factorization_unit and lyndon_checker

module tb_top;
    import lyndon_pkg::*;

    typedef logic [CHAR_W-1:0] char_q_t [$];

    logic         clk;
    logic         rst_n;
    logic         char_valid;
    logic         char_stall;
    char_word_t   char_word;
    logic         factor_valid;
    logic         factor_stall;
    factor_word_t factor_word;
    int           mismatches;
    int           factors_due;

    logic quiet;
    logic hold_req;
    logic hold_done;
    int   idle_pct;
    int   stall_pct;
    int   stall_burst;
    int   hold_left;
    int   sent_cnt;

    lyndon_factorization_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_word    (char_word),
        .factor_valid (factor_valid),
        .factor_stall (factor_stall),
        .factor_word  (factor_word)
    );

    lyndon_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_word    (char_word),
        .factor_valid (factor_valid),
        .factor_stall (factor_stall),
        .factor_word  (factor_word),
        .mismatches   (mismatches),
        .factors_due  (factors_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic fin);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_word  <= '{char_byte: ch, end_of_string: fin};
        do @(posedge clk); while (char_stall);
        @(negedge clk);
        sent_cnt++;
        if (sent_cnt >= 440)
            quiet = 1'b1;
    endtask

    task automatic send_string(input char_q_t s);
        for (int p = 0; p < s.size(); p++)
            send_char(s[p], p == s.size() - 1);
    endtask

    // periodic motifs from a narrow alphabet give repeated and nested factors; some strings are fully random bytes
    function automatic char_q_t make_string(input int len);
        char_q_t           s;
        logic [CHAR_W-1:0] motif [4];
        int                mlen;
        int                kind;
        int                base;
        kind = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
        mlen = $urandom_range(1, 4);
        for (int m = 0; m < 4; m++)
            motif[m] = CHAR_W'(base + $urandom_range(0, 2));
        for (int p = 0; p < len; p++)
        begin
            case (kind)
                0:       s = {s, CHAR_W'($urandom_range(0, 255))};
                1:       s = {s, CHAR_W'(base + $urandom_range(0, 2))};
                2:       s = {s, motif[p % mlen]};
                default: s = {s, ($urandom_range(0, 7) == 0)
                                 ? CHAR_W'(base + $urandom_range(0, 2)) : motif[p % mlen]};
            endcase
        end
        return s;
    endfunction

    // factor side: short random stall bursts plus one long hold-off
    initial
    begin
        factor_stall = 1'b0;
        stall_pct    = 20;
        stall_burst  = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 47) == 0)
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            if (hold_left > 0)
            begin
                hold_left--;
                factor_stall <= 1'b1;
            end
            else if (stall_burst > 0)
            begin
                stall_burst--;
                factor_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                stall_burst = $urandom_range(0, 3);
                factor_stall <= 1'b1;
            end
            else
                factor_stall <= 1'b0;
        end
    end

    initial
    begin
        char_q_t           s;
        int                len;
        int                r;
        int                nstr;
        logic [CHAR_W-1:0] fill;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_word  = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        idle_pct   = 0;
        sent_cnt   = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        s = '{8'hFF};                         send_string(s);
        s = '{8'h00};                         send_string(s);
        s = '{8'h00, 8'hFF};                  send_string(s);
        s = '{8'hFF, 8'h00};                  send_string(s);
        s = '{8'h55, 8'h55, 8'h55, 8'h55};    send_string(s);
        idle_pct = 30;
        s = '{8'h04, 8'h03, 8'h02, 8'h01};    send_string(s);
        s = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61}; send_string(s);
        s = '{8'h80, 8'h7F, 8'h80, 8'h81, 8'h7F}; send_string(s);

        sent_cnt = 0;
        nstr     = 0;
        while (sent_cnt < 500)
        begin
            // full store of one byte, then two strings that overflow the store, then random lengths
            if (nstr == 0)
            begin
                hold_req = 1'b1;
                fill = CHAR_W'($urandom_range(0, 255));
                s.delete();
                repeat (MAX_LEN_DEF) s = {s, fill};
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (nstr == 1)
                    len = MAX_LEN_DEF + 1;
                else if (nstr == 2)
                    len = MAX_LEN_DEF + 6;
                else if (r < 16)
                    len = $urandom_range(1, 12);
                else if (r < 18)
                    len = $urandom_range(13, MAX_LEN_DEF);
                else
                    len = $urandom_range(MAX_LEN_DEF + 1, MAX_LEN_DEF + 8);
                s = make_string(len);
            end
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 60;
            endcase
            send_string(s);
            nstr++;
        end
        char_valid <= 1'b0;

        wait (factors_due == 0);
        repeat (500) @(posedge clk);
        if (mismatches == 0 && factors_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
